// File: design/cls_pkg.sv
// Shared types, codes and fixed-point helpers of the Cholesky linear solver.
`default_nettype none
package cls_pkg;

  localparam int unsigned DW = 32;

  localparam logic signed [DW-1:0] VMAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] VMIN = 32'sh8000_0000;

  localparam logic [1:0] KIND_MAT   = 2'd0;
  localparam logic [1:0] KIND_RHS   = 2'd1;
  localparam logic [1:0] KIND_SOLVE = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [3:0]           row;
    logic [3:0]           col;
    logic signed [DW-1:0] value;
  } cls_in_t;

  typedef struct packed {
    logic [3:0]           index;
    logic signed [DW-1:0] solution;
    logic                 last;
    logic                 not_positive_definite;
  } cls_out_t;

  // solve phase
  typedef enum logic [1:0] {MODE_FAC, MODE_FWD, MODE_BWD, MODE_OUT} mode_e;

  // which operand the store reads address
  typedef enum logic [2:0] {RS_X, RS_Y, RS_BASE, RS_DIAG, RS_OUT} rsel_e;

  typedef struct packed {
    logic  accept;
    mode_e mode;
    logic  diag;
    rsel_e sel;
    logic  acc_clr;
    logic  lat_x;
    logic  mul;
    logic  acc;
    logic  lat_base;
    logic  ds_start;
    logic  wr_res;
    logic  emit;
    logic  last;
    logic  err;
  } cls_cmd_t;

  typedef struct packed {
    logic num_le0;
    logic ds_busy;
  } cls_sts_t;

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      sat_add = s[DW] ? VMIN : VMAX;
    end else begin
      sat_add = s[DW-1:0];
    end
  endfunction

  function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      sat_sub = s[DW] ? VMIN : VMAX;
    end else begin
      sat_sub = s[DW-1:0];
    end
  endfunction

  // Q16.16 product from the full 64-bit product: shift toward zero, saturate
  function automatic logic signed [DW-1:0] qmul_fix(input logic signed [2*DW-1:0] p);
    logic signed [2*DW-1:0] adj;
    logic signed [47:0]     sh;
    adj = p + (p[2*DW-1] ? 64'sd65535 : 64'sd0);
    sh  = adj[2*DW-1:16];
    if (sh[47:31] != {17{sh[47]}}) begin
      qmul_fix = sh[47] ? VMIN : VMAX;
    end else begin
      qmul_fix = sh[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: design/cls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: design/cls_divsqrt.sv
// Bit-serial unit: Q16.16 divide (one quotient bit a cycle) or square root.
`default_nettype none
module cls_divsqrt
  import cls_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 sqrt_i,
  input  wire logic signed [DW-1:0] num_i,
  input  wire logic signed [DW-1:0] den_i,
  output logic                      busy_o,
  output logic signed [DW-1:0]      result_o
);

  logic          busy_q;
  logic [5:0]    cnt_q;
  logic          sqrt_q, neg_q, dz_q;
  logic [47:0]   quo_q, root_q, bit_q;
  logic [DW:0]   rem_q;
  logic [DW-1:0] den_q;

  logic [DW-1:0] num_mag, den_mag;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [47:0]   trial;

  assign num_mag = num_i[DW-1] ? (~num_i + 32'd1) : num_i;
  assign den_mag = den_i[DW-1] ? (~den_i + 32'd1) : den_i;
  assign rem_sh  = {rem_q[DW-1:0], quo_q[47]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign trial   = root_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= sqrt_i || (den_mag != '0);
      cnt_q  <= sqrt_i ? 6'd23 : 6'd47;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sqrt_q <= sqrt_i;
      neg_q  <= num_i[DW-1] ^ den_i[DW-1];
      dz_q   <= !sqrt_i && (den_mag == '0);
      quo_q  <= {num_mag, 16'b0};
      rem_q  <= '0;
      den_q  <= den_mag;
      root_q <= '0;
      bit_q  <= 48'h4000_0000_0000;
    end else if (busy_q) begin
      if (sqrt_q) begin
        if (quo_q >= trial) begin
          quo_q  <= quo_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end else begin
        rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
        quo_q <= {quo_q[46:0], ge};
      end
    end
  end

  always_comb begin
    if (sqrt_q) begin
      result_o = root_q[DW-1:0];
    end else if (dz_q) begin
      result_o = neg_q ? VMIN : VMAX;
    end else if (neg_q) begin
      result_o = (quo_q > 48'h0000_8000_0000) ? VMIN : (~quo_q[DW-1:0] + 32'd1);
    end else begin
      result_o = (quo_q > 48'h0000_7fff_ffff) ? VMAX : quo_q[DW-1:0];
    end
  end

  assign busy_o = busy_q;

endmodule
`default_nettype wire

// File: design/cls_datapath.sv
// Datapath: stores, multiply-accumulate, divide/sqrt unit and result register.
`default_nettype none
module cls_datapath
  import cls_pkg::*;
#(
  parameter int unsigned MAX_DIM = 16,
  localparam int unsigned IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int unsigned CW    = IDX_W + 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cls_in_t        item_i,
  input  wire cls_cmd_t       cmd_i,
  input  wire logic [CW-1:0]  i_i,
  input  wire logic [CW-1:0]  k_i,
  input  wire logic [CW-1:0]  j_i,
  output cls_sts_t            sts_o,
  output cls_out_t            res_o,
  output logic                res_strobe_o
);

  localparam int unsigned MD = MAX_DIM * MAX_DIM;
  localparam int unsigned MW = (MD > 1) ? $clog2(MD) : 1;

  function automatic logic [MW-1:0] maddr(input logic [IDX_W-1:0] r,
                                          input logic [IDX_W-1:0] c);
    maddr = MW'(MW'(r) * MW'(MAX_DIM) + MW'(c));
  endfunction

  logic [IDX_W-1:0] ii, kk, jj, lr, lc;
  assign ii = i_i[IDX_W-1:0];
  assign kk = k_i[IDX_W-1:0];
  assign jj = j_i[IDX_W-1:0];
  assign lr = IDX_W'(item_i.row);
  assign lc = IDX_W'(item_i.col);

  logic row_ok, col_ok;
  assign row_ok = int'(item_i.row) < MAX_DIM;
  assign col_ok = int'(item_i.col) < MAX_DIM;

  logic signed [DW-1:0] ds_res;
  logic                 ds_busy;

  // matrix store
  logic          mat_we;
  logic [MW-1:0] mat_wa, mat_ra;
  logic [DW-1:0] mat_wd, mat_rd;

  assign mat_we = (cmd_i.accept && item_i.kind == KIND_MAT && row_ok && col_ok) ||
                  (cmd_i.wr_res && cmd_i.mode == MODE_FAC);
  assign mat_wa = cmd_i.wr_res ? maddr(ii, kk) : maddr(lr, lc);
  assign mat_wd = cmd_i.wr_res ? ds_res : item_i.value;

  always_comb begin
    case (cmd_i.sel)
      RS_X:    mat_ra = (cmd_i.mode == MODE_BWD) ? maddr(jj, ii) : maddr(ii, jj);
      RS_Y:    mat_ra = maddr(kk, jj);
      RS_BASE: mat_ra = maddr(ii, kk);
      RS_DIAG: mat_ra = (cmd_i.mode == MODE_FAC) ? maddr(kk, kk) : maddr(ii, ii);
      default: mat_ra = maddr(ii, ii);
    endcase
  end

  cls_ram #(.WIDTH(DW), .DEPTH(MD)) u_mat (
    .clk_i   (clk_i),
    .we_i    (mat_we),
    .waddr_i (mat_wa),
    .wdata_i (mat_wd),
    .raddr_i (mat_ra),
    .rdata_o (mat_rd)
  );

  // right-hand side
  logic [DW-1:0] rhs_rd;

  cls_ram #(.WIDTH(DW), .DEPTH(MAX_DIM)) u_rhs (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && item_i.kind == KIND_RHS && row_ok),
    .waddr_i (lr),
    .wdata_i (item_i.value),
    .raddr_i (ii),
    .rdata_o (rhs_rd)
  );

  // y, then d
  logic [DW-1:0] work_rd;

  cls_ram #(.WIDTH(DW), .DEPTH(MAX_DIM)) u_work (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_res && cmd_i.mode != MODE_FAC),
    .waddr_i (ii),
    .wdata_i (ds_res),
    .raddr_i ((cmd_i.sel == RS_Y) ? jj : ii),
    .rdata_o (work_rd)
  );

  logic signed [DW-1:0]   opa_q, acc_q, num_q, y_dat, base_dat;
  logic signed [2*DW-1:0] prod_q;
  cls_out_t               res_q;
  logic                   strobe_q;

  assign y_dat = (cmd_i.mode == MODE_FAC) ? mat_rd : work_rd;

  always_comb begin
    case (cmd_i.mode)
      MODE_FAC: base_dat = mat_rd;
      MODE_FWD: base_dat = rhs_rd;
      default:  base_dat = work_rd;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_x) begin
      opa_q <= mat_rd;
    end
    if (cmd_i.mul) begin
      prod_q <= opa_q * y_dat;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      acc_q <= sat_add(acc_q, qmul_fix(prod_q));
    end
    if (cmd_i.lat_base) begin
      num_q <= sat_sub(base_dat, acc_q);
    end
    if (cmd_i.emit) begin
      res_q.index                 <= 4'(i_i);
      res_q.solution              <= cmd_i.err ? '0 : work_rd;
      res_q.last                  <= cmd_i.last;
      res_q.not_positive_definite <= cmd_i.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  cls_divsqrt u_ds (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.ds_start),
    .sqrt_i   (cmd_i.diag),
    .num_i    (num_q),
    .den_i    (mat_rd),
    .busy_o   (ds_busy),
    .result_o (ds_res)
  );

  assign sts_o.num_le0 = num_q[DW-1] || (num_q == '0);
  assign sts_o.ds_busy = ds_busy;
  assign res_o         = res_q;
  assign res_strobe_o  = strobe_q;

endmodule
`default_nettype wire

// File: design/cls_ctrl.sv
// Controller: loop counters and sequencing of factor, substitution and output.
`default_nettype none
module cls_ctrl
  import cls_pkg::*;
#(
  parameter int unsigned MAX_DIM = 16,
  localparam int unsigned IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int unsigned CW    = IDX_W + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic [1:0]    kind_i,
  output logic               busy,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [4:0]    cfg_data_i,
  input  wire cls_sts_t      sts_i,
  output cls_cmd_t           cmd_o,
  output logic [CW-1:0]      i_o,
  output logic [CW-1:0]      k_o,
  output logic [CW-1:0]      j_o
);

  localparam int unsigned NMAX = (MAX_DIM < 16) ? MAX_DIM : 16;

  typedef enum logic [3:0] {
    S_IDLE, S_ELEM, S_CHK, S_RX, S_RY, S_MUL, S_ACC, S_BASE, S_BLAT,
    S_DSTART, S_DWAIT, S_WRITE, S_OUT_RD, S_OUT_EM
  } state_e;

  state_e        state_q;
  mode_e         mode_q;
  logic [CW-1:0] i_q, k_q, j_q, n_q;
  logic          err_q;
  logic [4:0]    size_q;

  logic [CW-1:0] n_sel, j_start, j_end;
  logic          diag, idle;

  assign idle = state_q == S_IDLE;
  assign diag = (mode_q == MODE_FAC) && (k_q == i_q);

  always_comb begin
    if (size_q == '0) begin
      n_sel = CW'(1);
    end else if (int'(size_q) > NMAX) begin
      n_sel = CW'(NMAX);
    end else begin
      n_sel = CW'(size_q);
    end
  end

  always_comb begin
    case (mode_q)
      MODE_FAC: begin j_start = '0;         j_end = k_q; end
      MODE_FWD: begin j_start = '0;         j_end = i_q; end
      default:  begin j_start = i_q + 1'b1; j_end = n_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_FAC;
      i_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      err_q   <= 1'b0;
      size_q  <= 5'd16;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            size_q <= cfg_data_i;
          end
          if (start && kind_i == KIND_SOLVE) begin
            n_q     <= n_sel;
            err_q   <= 1'b0;
            mode_q  <= MODE_FAC;
            i_q     <= '0;
            k_q     <= '0;
            state_q <= S_ELEM;
          end
        end
        S_ELEM: begin
          j_q     <= j_start;
          state_q <= S_CHK;
        end
        S_CHK:  state_q <= (j_q == j_end) ? S_BASE : S_RX;
        S_RX:   state_q <= S_RY;
        S_RY:   state_q <= S_MUL;
        S_MUL:  state_q <= S_ACC;
        S_ACC: begin
          j_q     <= j_q + 1'b1;
          state_q <= S_CHK;
        end
        S_BASE: state_q <= S_BLAT;
        S_BLAT: state_q <= S_DSTART;
        S_DSTART: begin
          if (diag && sts_i.num_le0) begin
            // radicand not positive: abandon factoring, report zeros
            err_q   <= 1'b1;
            mode_q  <= MODE_OUT;
            i_q     <= '0;
            state_q <= S_OUT_RD;
          end else begin
            state_q <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (!sts_i.ds_busy) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          state_q <= S_ELEM;
          case (mode_q)
            MODE_FAC: begin
              if (diag) begin
                k_q <= '0;
                if (i_q + 1'b1 == n_q) begin
                  mode_q <= MODE_FWD;
                  i_q    <= '0;
                end else begin
                  i_q <= i_q + 1'b1;
                end
              end else begin
                k_q <= k_q + 1'b1;
              end
            end
            MODE_FWD: begin
              if (i_q + 1'b1 == n_q) begin
                mode_q <= MODE_BWD;
                i_q    <= n_q - 1'b1;
              end else begin
                i_q <= i_q + 1'b1;
              end
            end
            default: begin
              if (i_q == '0) begin
                mode_q  <= MODE_OUT;
                state_q <= S_OUT_RD;
              end else begin
                i_q <= i_q - 1'b1;
              end
            end
          endcase
        end
        S_OUT_RD: state_q <= S_OUT_EM;
        S_OUT_EM: begin
          if (i_q + 1'b1 == n_q) begin
            state_q <= S_IDLE;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_OUT_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = start && idle;
    cmd_o.mode     = mode_q;
    cmd_o.diag     = diag;
    cmd_o.err      = err_q;
    cmd_o.last     = (i_q + 1'b1 == n_q);
    cmd_o.acc_clr  = state_q == S_ELEM;
    cmd_o.lat_x    = state_q == S_RY;
    cmd_o.mul      = state_q == S_MUL;
    cmd_o.acc      = state_q == S_ACC;
    cmd_o.lat_base = state_q == S_BLAT;
    cmd_o.ds_start = (state_q == S_DSTART) && !(diag && sts_i.num_le0);
    cmd_o.wr_res   = state_q == S_WRITE;
    cmd_o.emit     = state_q == S_OUT_EM;
    unique case (state_q)
      S_RY:     cmd_o.sel = RS_Y;
      S_BASE:   cmd_o.sel = RS_BASE;
      S_BLAT:   cmd_o.sel = RS_DIAG;
      S_OUT_RD: cmd_o.sel = RS_OUT;
      default:  cmd_o.sel = RS_X;
    endcase
  end

  assign busy        = !idle;
  assign cfg_ready_o = idle;
  assign i_o         = i_q;
  assign k_o         = k_q;
  assign j_o         = j_q;

endmodule
`default_nettype wire

// File: design/cholesky_linear_solve.sv
// Top level of the Cholesky linear solver: controller plus datapath.
//
// Usage: an item transfers on a rising edge with start high and busy low.
// Kind 0 writes K[row][col], kind 1 writes f[row]; both finish in that
// cycle and busy stays low, so loads stream one per cycle. Kind 2 solves
// K d = f for the n x n leading system (n from the size register) and raises
// busy until the last solution element has been issued. K is factored in
// place, so a later solve without reloading K factors the stored L.
// Results come one per element in index order, each on res_o for a single
// cycle with res_strobe_o high; the receiver has to take them as they come.
// A solve runs a multiply-accumulate loop for every factor and substitution
// element, then one divide or one square root in the shared bit-serial unit,
// then the results are issued; the serial divider dominates for small n.
// A non-positive radicand stops factoring; all n results then carry zero and
// the not_positive_definite flag. The size register (cfg_*) is written only
// while busy is low. Reset sets the size to 16 and leaves the stores unset.
`default_nettype none
module cholesky_linear_solve
  import cls_pkg::*;
#(
  parameter int unsigned MAX_DIM = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire cls_in_t    item_i,
  output cls_out_t        res_o,
  output logic            res_strobe_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [4:0] cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CW    = IDX_W + 1;

  cls_cmd_t      cmd;
  cls_sts_t      sts;
  logic [CW-1:0] i_idx, k_idx, j_idx;

  cls_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .kind_i      (item_i.kind),
    .busy        (busy),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .i_o         (i_idx),
    .k_o         (k_idx),
    .j_o         (j_idx)
  );

  cls_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .cmd_i        (cmd),
    .i_i          (i_idx),
    .k_i          (k_idx),
    .j_i          (j_idx),
    .sts_o        (sts),
    .res_o        (res_o),
    .res_strobe_o (res_strobe_o)
  );

endmodule
`default_nettype wire
